>>> rtl/ethernet_l3_l4_header_parser_macros.svh
// ----------------------------------------------------------------------------
// ethernet_l3_l4_header_parser_macros
// assertion macros for the header parser, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ETHERNET_L3_L4_HEADER_PARSER_MACROS_SVH
`define ETHERNET_L3_L4_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define EL34HP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("header parser check failed");

`define EL34HP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("header parser check failed");

`else

`define EL34HP_ASSERT_SAME(label, clk, rst, ante, cons)

`define EL34HP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/el34hp_pkg.sv
// ----------------------------------------------------------------------------
// el34hp_pkg
// shared types and constants of the ethernet l3/l4 header parser
// ----------------------------------------------------------------------------
`default_nettype none

package el34hp_pkg;

  localparam logic [15:0] ETYPE_IP  = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  localparam logic [7:0] PR_ICMP   = 8'd1;
  localparam logic [7:0] PR_TCP    = 8'd6;
  localparam logic [7:0] PR_UDP    = 8'd17;
  localparam logic [7:0] PR_ICMPV6 = 8'd58;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;

  // last byte position a frame must reach to be kept
  localparam logic [5:0] LAST_V4_TU  = 6'd37;
  localparam logic [5:0] LAST_V4_IC  = 6'd33;
  localparam logic [5:0] LAST_V6_TU  = 6'd57;
  localparam logic [5:0] LAST_V6_IC  = 6'd53;
  localparam logic [5:0] LAST_ARP    = 6'd41;

  localparam logic [5:0] OFFSET_V4 = 6'd34;
  localparam logic [5:0] OFFSET_V6 = 6'd54;

  localparam logic [5:0] POS_MAX = 6'd63;

  typedef struct packed {
    logic        accept;
    logic        family_v6;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  transport_offset;
  } result_t;

  typedef struct packed {
    logic [15:0] etype;
    logic [3:0]  version;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

endpackage

`default_nettype wire

>>> rtl/el34hp_parse.sv
// ----------------------------------------------------------------------------
// el34hp_parse
// per-frame header capture and the verdict for the frame's last byte
// ----------------------------------------------------------------------------
`default_nettype none

module el34hp_parse (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     step,
  input  wire  [7:0]              frame_byte,
  input  wire                     frame_end,
  output el34hp_pkg::result_t     res
);

  import el34hp_pkg::*;

  hdr_t       hdr;
  hdr_t       hdr_next;
  logic [5:0] pos;
  logic [5:0] pos_next;

  logic is_ip;
  logic is_arp;
  logic v4;
  logic tu;
  logic ic;
  logic v6;
  logic ok;
  logic [5:0] last_need;

  assign is_ip    = hdr.etype == ETYPE_IP;
  assign is_arp   = hdr.etype == ETYPE_ARP;
  assign v4       = hdr.version == IP_VERSION_4;
  assign pos_next = (pos == POS_MAX) ? pos : pos + 6'd1;

  always_comb begin
    hdr_next = hdr;
    if (pos == 6'd12 || pos == 6'd13) begin
      hdr_next.etype = {hdr.etype[7:0], frame_byte};
    end else if (pos == 6'd14) begin
      hdr_next.version = frame_byte[7:4];
    end else if (is_ip && v4) begin
      if (pos == 6'd23) begin
        hdr_next.proto = frame_byte;
      end else if (pos >= 6'd26 && pos <= 6'd29) begin
        hdr_next.src_lo = {hdr.src_lo[55:0], frame_byte};
      end else if (pos >= 6'd30 && pos <= 6'd33) begin
        hdr_next.dst_lo = {hdr.dst_lo[55:0], frame_byte};
      end else if (pos == 6'd34 || pos == 6'd35) begin
        hdr_next.sport = {hdr.sport[7:0], frame_byte};
      end else if (pos == 6'd36 || pos == 6'd37) begin
        hdr_next.dport = {hdr.dport[7:0], frame_byte};
      end
    end else if (is_ip) begin
      if (pos == 6'd20) begin
        hdr_next.proto = frame_byte;
      end else if (pos >= 6'd22 && pos <= 6'd29) begin
        hdr_next.src_hi = {hdr.src_hi[55:0], frame_byte};
      end else if (pos >= 6'd30 && pos <= 6'd37) begin
        hdr_next.src_lo = {hdr.src_lo[55:0], frame_byte};
      end else if (pos >= 6'd38 && pos <= 6'd45) begin
        hdr_next.dst_hi = {hdr.dst_hi[55:0], frame_byte};
      end else if (pos >= 6'd46 && pos <= 6'd53) begin
        hdr_next.dst_lo = {hdr.dst_lo[55:0], frame_byte};
      end else if (pos == 6'd54 || pos == 6'd55) begin
        hdr_next.sport = {hdr.sport[7:0], frame_byte};
      end else if (pos == 6'd56 || pos == 6'd57) begin
        hdr_next.dport = {hdr.dport[7:0], frame_byte};
      end
    end else if (is_arp) begin
      if (pos >= 6'd28 && pos <= 6'd31) begin
        hdr_next.src_lo = {hdr.src_lo[55:0], frame_byte};
      end else if (pos >= 6'd38 && pos <= 6'd41) begin
        hdr_next.dst_lo = {hdr.dst_lo[55:0], frame_byte};
      end
    end
  end

  // verdict from the header including this byte
  assign tu = hdr_next.proto == PR_TCP || hdr_next.proto == PR_UDP;
  assign ic = hdr_next.proto == PR_ICMP || hdr_next.proto == PR_ICMPV6;
  assign v6 = hdr_next.version != IP_VERSION_4;

  always_comb begin
    if (v6) begin
      last_need = tu ? LAST_V6_TU : LAST_V6_IC;
    end else begin
      last_need = tu ? LAST_V4_TU : LAST_V4_IC;
    end
  end

  always_comb begin
    ok = 1'b0;
    if (hdr_next.etype == ETYPE_IP) begin
      ok = (tu || ic) && pos >= last_need;
    end else if (hdr_next.etype == ETYPE_ARP) begin
      ok = pos >= LAST_ARP;
    end
  end

  always_comb begin
    res            = '0;
    res.ether_type = hdr_next.etype;
    if (ok) begin
      res.accept      = 1'b1;
      res.src_addr_lo = hdr_next.src_lo;
      res.dst_addr_lo = hdr_next.dst_lo;
      if (hdr_next.etype == ETYPE_IP) begin
        res.family_v6        = v6;
        res.ip_protocol      = hdr_next.proto;
        res.transport_offset = v6 ? OFFSET_V6 : OFFSET_V4;
        if (v6) begin
          res.src_addr_hi = hdr_next.src_hi;
          res.dst_addr_hi = hdr_next.dst_hi;
        end
        if (tu) begin
          res.src_port = hdr_next.sport;
          res.dst_port = hdr_next.dport;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= '0;
      pos <= '0;
    end else if (step) begin
      if (frame_end) begin
        hdr <= '0;
        pos <= '0;
      end else begin
        hdr <= hdr_next;
        pos <= pos_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ethernet_l3_l4_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_l3_l4_header_parser
// parses ethernet, ipv4/ipv6/arp and tcp/udp headers from a byte stream
// ----------------------------------------------------------------------------
// Frames enter one byte per item on the slave side, tlast on the final byte,
// and one byte is taken every cycle but for the stall below. For each frame,
// one result item leaves on the master side: the last byte waits in the
// input register, then the header capture and verdict logic loads the output
// register. Bytes keep flowing while a result waits; only a frame's last byte
// stalls, and only while the previous result has not been taken.
`default_nettype none

module ethernet_l3_l4_header_parser (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,  // frame_byte
  input  wire          s_axis_tlast,  // frame_end
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // ether_type, ip_protocol, src_addr_hi, src_addr_lo, dst_addr_hi,
  // dst_addr_lo, src_port, dst_port, transport_offset, 2 zero bits
  output logic [319:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // accept, family_v6
);

  import el34hp_pkg::*;

  `include "ethernet_l3_l4_header_parser_macros.svh"

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_end;
  logic       move;
  logic       load;
  result_t    res;
  result_t    out_res;
  logic       out_valid;

  assign move          = in_valid && (!in_end || !out_valid || m_axis_tready);
  assign load          = move && in_end;
  assign s_axis_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  el34hp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (move),
    .frame_byte (in_byte),
    .frame_end  (in_end),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_res.family_v6, out_res.accept};
  assign m_axis_tdata  = {2'b00,
                          out_res.transport_offset,
                          out_res.dst_port,
                          out_res.src_port,
                          out_res.dst_addr_lo,
                          out_res.dst_addr_hi,
                          out_res.src_addr_lo,
                          out_res.src_addr_hi,
                          out_res.ip_protocol,
                          out_res.ether_type};

  `EL34HP_ASSERT_SAME(a_v6_offset, clk, rst,
    out_valid && out_res.accept && out_res.family_v6,
    out_res.transport_offset == OFFSET_V6)

  `EL34HP_ASSERT_SAME(a_drop_clean, clk, rst,
    out_valid && !out_res.accept,
    out_res.transport_offset == 6'd0 && out_res.src_port == 16'd0 && !out_res.family_v6)

  `EL34HP_ASSERT_NEXT(a_taken_clears, clk, rst,
    out_valid && m_axis_tready && !load,
    !out_valid)

  `EL34HP_ASSERT_SAME(a_end_stall, clk, rst,
    in_valid && in_end && out_valid && !m_axis_tready,
    !s_axis_tready)

endmodule

`default_nettype wire

>>> dv/el34hp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// el34hp_result_checker
// follows the byte stream into the header parser, works out the verdict and
// header fields each frame should give, and compares them with the results
// ----------------------------------------------------------------------------

module el34hp_result_checker
  import el34hp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [319:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           n_errors,
  output int           n_pending,
  output int           n_results,
  output int           n_kept
);

  hdr_t       hdr;
  logic [5:0] pos;
  result_t    parsed_q[$];

  initial begin
    n_errors  = 0;
    n_pending = 0;
    n_results = 0;
    n_kept    = 0;
  end

  // header capture and verdict for one frame byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic    is_ip;
    logic    is_arp;
    logic    is_v4;
    logic    tu;
    logic    ic;
    logic    v6;
    logic    ok;
    logic [5:0] p;
    result_t r;
    is_ip  = hdr.etype == ETYPE_IP;
    is_arp = hdr.etype == ETYPE_ARP;
    is_v4  = hdr.version == IP_VERSION_4;
    p      = pos;
    if (p == 6'd12 || p == 6'd13) begin
      hdr.etype = {hdr.etype[7:0], b};
    end else if (p == 6'd14) begin
      hdr.version = b[7:4];
    end else if (is_ip && is_v4) begin
      if (p == 6'd23) hdr.proto = b;
      else if (p >= 6'd26 && p <= 6'd29) hdr.src_lo = {hdr.src_lo[55:0], b};
      else if (p >= 6'd30 && p <= 6'd33) hdr.dst_lo = {hdr.dst_lo[55:0], b};
      else if (p == 6'd34 || p == 6'd35) hdr.sport = {hdr.sport[7:0], b};
      else if (p == 6'd36 || p == 6'd37) hdr.dport = {hdr.dport[7:0], b};
    end else if (is_ip) begin
      if (p == 6'd20) hdr.proto = b;
      else if (p >= 6'd22 && p <= 6'd29) hdr.src_hi = {hdr.src_hi[55:0], b};
      else if (p >= 6'd30 && p <= 6'd37) hdr.src_lo = {hdr.src_lo[55:0], b};
      else if (p >= 6'd38 && p <= 6'd45) hdr.dst_hi = {hdr.dst_hi[55:0], b};
      else if (p >= 6'd46 && p <= 6'd53) hdr.dst_lo = {hdr.dst_lo[55:0], b};
      else if (p == 6'd54 || p == 6'd55) hdr.sport = {hdr.sport[7:0], b};
      else if (p == 6'd56 || p == 6'd57) hdr.dport = {hdr.dport[7:0], b};
    end else if (is_arp) begin
      if (p >= 6'd28 && p <= 6'd31) hdr.src_lo = {hdr.src_lo[55:0], b};
      else if (p >= 6'd38 && p <= 6'd41) hdr.dst_lo = {hdr.dst_lo[55:0], b};
    end
    if (pos != POS_MAX) pos = pos + 6'd1;
    if (!last) return;

    r            = '0;
    r.ether_type = hdr.etype;
    ok = 1'b0;
    v6 = 1'b0;
    tu = 1'b0;
    if (hdr.etype == ETYPE_IP) begin
      tu = hdr.proto == PR_TCP || hdr.proto == PR_UDP;
      ic = hdr.proto == PR_ICMP || hdr.proto == PR_ICMPV6;
      v6 = hdr.version != IP_VERSION_4;
      if (v6) ok = (tu && p >= LAST_V6_TU) || (ic && p >= LAST_V6_IC);
      else    ok = (tu && p >= LAST_V4_TU) || (ic && p >= LAST_V4_IC);
    end else if (hdr.etype == ETYPE_ARP) begin
      ok = p >= LAST_ARP;
    end
    if (ok) begin
      r.accept      = 1'b1;
      r.family_v6   = v6;
      r.ip_protocol = (hdr.etype == ETYPE_IP) ? hdr.proto : 8'd0;
      r.src_addr_hi = v6 ? hdr.src_hi : 64'd0;
      r.src_addr_lo = hdr.src_lo;
      r.dst_addr_hi = v6 ? hdr.dst_hi : 64'd0;
      r.dst_addr_lo = hdr.dst_lo;
      r.src_port    = tu ? hdr.sport : 16'd0;
      r.dst_port    = tu ? hdr.dport : 16'd0;
      if (hdr.etype == ETYPE_IP) r.transport_offset = v6 ? OFFSET_V6 : OFFSET_V4;
    end
    parsed_q.push_back(r);
    hdr = '0;
    pos = '0;
  endtask

  function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      bad;
    if (rst) begin
      hdr = '0;
      pos = '0;
      parsed_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results <= n_results + 1;
        if (parsed_q.size() == 0) begin
          $error("result item with no frame waiting for one");
          n_errors <= n_errors + 1;
        end else begin
          want = parsed_q.pop_front();
          bad  = 0;
          bad += field_diff("accept", want.accept, m_axis_tuser[0]);
          bad += field_diff("family_v6", want.family_v6, m_axis_tuser[1]);
          bad += field_diff("ether_type", want.ether_type, m_axis_tdata[15:0]);
          bad += field_diff("ip_protocol", want.ip_protocol, m_axis_tdata[23:16]);
          bad += field_diff("src_addr_hi", want.src_addr_hi, m_axis_tdata[87:24]);
          bad += field_diff("src_addr_lo", want.src_addr_lo, m_axis_tdata[151:88]);
          bad += field_diff("dst_addr_hi", want.dst_addr_hi, m_axis_tdata[215:152]);
          bad += field_diff("dst_addr_lo", want.dst_addr_lo, m_axis_tdata[279:216]);
          bad += field_diff("src_port", want.src_port, m_axis_tdata[295:280]);
          bad += field_diff("dst_port", want.dst_port, m_axis_tdata[311:296]);
          bad += field_diff("transport_offset", want.transport_offset,
                            m_axis_tdata[317:312]);
          bad += field_diff("tdata_pad", 64'd0, m_axis_tdata[319:318]);
          n_errors <= n_errors + bad;
          if (want.accept) n_kept <= n_kept + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
    end
    n_pending <= parsed_q.size();
  end

endmodule

>>> dv/tb_ethernet_l3_l4_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ethernet_l3_l4_header_parser
// drives ipv4, ipv6, arp, foreign and noise frames of varied length into the
// header parser with random gaps and output stalls; a checker module beside
// the block predicts and compares every result
// ----------------------------------------------------------------------------

module tb_ethernet_l3_l4_header_parser;
  import el34hp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {FR_V4, FR_V6, FR_ARP, FR_OTHER, FR_NOISE} frame_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;   // frame_byte
  logic         s_axis_tlast = 1'b0;   // frame_end
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [319:0] m_axis_tdata;          // ether_type .. transport_offset, pad
  logic [1:0]   m_axis_tuser;          // accept, family_v6

  int n_errors;
  int n_pending;
  int n_results;
  int n_kept;

  int   cycles = 0;
  int   stall_left = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  bit   calm = 1'b0;
  int   n_bytes = 0;
  int   n_frames = 0;
  logic [7:0] frame_q[$];

  always #10 clk = ~clk;

  ethernet_l3_l4_header_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  el34hp_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .n_errors      (n_errors),
    .n_pending     (n_pending),
    .n_results     (n_results),
    .n_kept        (n_kept)
  );

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rst && !calm && $urandom_range(99) < stall_pct) begin
      stall_left    <= $urandom_range(17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[ethernet_l3_l4_header_parser] ERROR");
      $finish;
    end
  end

  task automatic put(input int idx, input logic [7:0] v);
    if (idx < frame_q.size()) frame_q[idx] = v;
  endtask

  task automatic build_frame(input frame_kind_t kind, input logic [7:0] proto,
                             input logic [15:0] etype, input int len);
    logic [3:0] ver;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    ver = 4'($urandom);
    if (ver == IP_VERSION_4 || $urandom_range(1)) ver = 4'd6;
    case (kind)
      FR_V4: begin
        put(12, ETYPE_IP[15:8]);
        put(13, ETYPE_IP[7:0]);
        put(14, {IP_VERSION_4, 4'($urandom)});
        put(23, proto);
      end
      FR_V6: begin
        put(12, ETYPE_IP[15:8]);
        put(13, ETYPE_IP[7:0]);
        put(14, {ver, 4'($urandom)});
        put(20, proto);
      end
      FR_ARP: begin
        put(12, ETYPE_ARP[15:8]);
        put(13, ETYPE_ARP[7:0]);
      end
      FR_OTHER: begin
        put(12, etype[15:8]);
        put(13, etype[7:0]);
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    n_frames++;
  endtask

  task automatic run_frame(input frame_kind_t kind, input logic [7:0] proto,
                           input logic [15:0] etype, input int len);
    build_frame(kind, proto, etype, len);
    send_frame();
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0: return PR_TCP;
      1: return PR_UDP;
      2: return PR_ICMP;
      3: return PR_ICMPV6;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_etype();
    case ($urandom_range(2))
      0: return 16'h86dd;
      1: return {8'h08, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  // lengths cluster around the point where a frame becomes long enough
  function automatic int pick_len(frame_kind_t kind, logic [7:0] proto);
    logic tu;
    int   need;
    tu = proto == PR_TCP || proto == PR_UDP;
    case (kind)
      FR_V4:   need = tu ? 38 : 34;
      FR_V6:   need = tu ? 58 : 54;
      FR_ARP:  need = 42;
      default: need = 14;
    endcase
    if ($urandom_range(9) == 0) return $urandom_range(1, 100);
    return need - 3 + $urandom_range(10);
  endfunction

  initial begin
    frame_kind_t kind;
    logic [7:0]  proto;
    int          pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames
    gap_pct   = 10;
    stall_pct = 10;
    run_frame(FR_NOISE, 8'd0, 16'd0, 1);
    run_frame(FR_V4, PR_TCP, 16'd0, 38);
    run_frame(FR_V4, PR_TCP, 16'd0, 37);
    run_frame(FR_V4, PR_UDP, 16'd0, 38);
    run_frame(FR_V4, PR_ICMP, 16'd0, 34);
    run_frame(FR_V4, PR_ICMP, 16'd0, 33);
    run_frame(FR_V4, PR_ICMPV6, 16'd0, 34);
    run_frame(FR_V4, 8'd0, 16'd0, 60);
    run_frame(FR_V4, 8'hff, 16'd0, 60);
    run_frame(FR_V6, PR_TCP, 16'd0, 58);
    run_frame(FR_V6, PR_UDP, 16'd0, 57);
    run_frame(FR_V6, PR_ICMP, 16'd0, 54);
    run_frame(FR_V6, PR_ICMPV6, 16'd0, 53);
    run_frame(FR_V6, 8'hff, 16'd0, 60);
    run_frame(FR_ARP, 8'd0, 16'd0, 42);
    run_frame(FR_ARP, 8'd0, 16'd0, 41);
    run_frame(FR_OTHER, 8'd0, 16'h0000, 50);
    run_frame(FR_OTHER, 8'd0, 16'h86dd, 70);
    // long frame of all ones, then a short one of all zeros
    build_frame(FR_NOISE, 8'd0, 16'd0, 90);
    foreach (frame_q[i]) frame_q[i] = 8'hff;
    send_frame();
    build_frame(FR_NOISE, 8'd0, 16'd0, 20);
    foreach (frame_q[i]) frame_q[i] = 8'h00;
    send_frame();
    run_frame(FR_V6, PR_UDP, 16'd0, 80);

    // random frames
    while (n_bytes < 1900) begin
      if (n_frames % 8 == 0) begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 5;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 30;
        endcase
      end
      if (n_bytes > 1550) calm = 1'b1;
      pick = $urandom_range(99);
      if (pick < 35)      kind = FR_V4;
      else if (pick < 65) kind = FR_V6;
      else if (pick < 80) kind = FR_ARP;
      else if (pick < 90) kind = FR_OTHER;
      else                kind = FR_NOISE;
      proto = pick_proto();
      run_frame(kind, proto, pick_etype(), pick_len(kind, proto));
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    do @(posedge clk); while (n_pending != 0);
    repeat (20) @(posedge clk);

    $display("sent %0d frames in %0d bytes, gaps and stalls on both sides",
             n_frames, n_bytes);
    $display("checked %0d results, %0d kept and %0d dropped",
             n_results, n_kept, n_results - n_kept);
    if (n_errors == 0 && n_pending == 0) begin
      $display("[ethernet_l3_l4_header_parser] OK");
    end else begin
      $display("[ethernet_l3_l4_header_parser] ERROR");
    end
    $finish;
  end

endmodule
